[design/assert_macros.svh]
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

[design/ntc_pkg.sv]
package ntc_pkg;

   // field widths
   localparam int NtpW   = 32;
   localparam int TzW    = 17;
   localparam int YearW  = 11;
   localparam int MonW   = 4;
   localparam int DomW   = 5;
   localparam int HourW  = 5;
   localparam int MinW   = 6;
   localparam int SecW   = 6;
   localparam int WdayW  = 3;

   localparam int NtcQueueDepth = 2;

   localparam logic [TzW-1:0] TzReset = TzW'(9 * 60 * 60);

   // seconds per day = 2^7 * 675; the odd factor is divided by reciprocal
   localparam logic [9:0]  DayOdd    = 10'd675;
   localparam logic [24:0] DayRecip  = 25'(64'(2) ** 34 / 675);

   localparam logic [21:0] CjdEpoch  = 22'd2415021;
   localparam logic [23:0] CentBias  = 24'd128179;
   localparam logic [17:0] GregCycle = 18'd146097;
   localparam logic [23:0] Cent67At  = 24'(67 * 146097);
   localparam logic [23:0] Cent68At  = 24'(68 * 146097);

   localparam logic [10:0] QuadYear  = 11'd1461;
   localparam logic [17:0] YearRecip = 18'((64'(1) << 28) / 1461);
   localparam logic [7:0]  MonSpan   = 8'd153;
   localparam logic [8:0]  MonRecip  = 9'((1 << 16) / 153);
   localparam logic [7:0]  DomRecip  = 8'(((1 << 10) + 4) / 5);

   localparam logic [5:0]  Sixty     = 6'd60;
   localparam logic [16:0] MinRecip  = 17'((1 << 22) / 60);
   localparam logic [10:0] HourRecip = 11'((1 << 16) / 60);
   localparam logic [16:0] WdRecip   = 17'((1 << 19) / 7);
   localparam logic [2:0]  Seven     = 3'd7;

   localparam logic [12:0] YearBias  = 13'd4800;

   // word handed from the front end to the queue
   typedef struct packed {
      logic            valid;
      logic [NtpW-1:0] local_secs;
   } ntc_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ntc_qstat_type;

endpackage

[design/ntc_front.sv]
module ntc_front
   import ntc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [NtpW-1:0]       req_ntp_seconds,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic signed [TzW-1:0] csr_timezone_offset,
   input  logic                  push_ready,
   output ntc_push_type          push
);

   logic [NtpW-1:0] last_ff, last_in;
   logic [TzW-1:0]  tz_ff, tz_in;
   logic            take;
   logic            newer;

   assign req_ready = push_ready;
   assign csr_ready = 1'b1;
   assign take      = req_valid && push_ready;
   assign newer     = req_ntp_seconds > last_ff;

   always_comb begin
      last_in = last_ff;
      tz_in   = tz_ff;
      if (take && newer) begin
         last_in = req_ntp_seconds;
      end
      if (csr_valid) begin
         tz_in = csr_timezone_offset;
      end
      push.valid      = take && newer;
      // add the sign-extended offset, wrap modulo 2^32
      push.local_secs = req_ntp_seconds + {{(NtpW-TzW){tz_ff[TzW-1]}}, tz_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         tz_ff   <= TzReset;
      end else begin
         last_ff <= last_in;
         tz_ff   <= tz_in;
      end
   end

endmodule

[design/ntc_queue.sv]
module ntc_queue
   import ntc_pkg::*;
#(
   parameter int Depth = NtcQueueDepth
)
(
   input  logic            clock,
   input  logic            reset,
   input  ntc_push_type    push,
   output logic            push_ready,
   output logic            pop_valid,
   input  logic            pop_ready,
   output logic [NtpW-1:0] pop_data,
   output ntc_qstat_type   stat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [NtpW-1:0] entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign stat.full  = count_ff == CntW'(Depth);
   assign stat.empty = count_ff == '0;
   assign push_ready = !stat.full;
   assign pop_valid  = !stat.empty;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.local_secs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/ntc_back.sv]
module ntc_back
   import ntc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [NtpW-1:0]  in_local,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [YearW-1:0] rsp_year,
   output logic [MonW-1:0]  rsp_month,
   output logic [DomW-1:0]  rsp_day_of_month,
   output logic [HourW-1:0] rsp_hour,
   output logic [MinW-1:0]  rsp_minute,
   output logic [SecW-1:0]  rsp_second,
   output logic [WdayW-1:0] rsp_weekday,
   output logic             rsp_resync_request
);

   localparam int Stages = 11;

   typedef struct packed {
      logic [24:0] x;
      logic [6:0]  lo7;
      logic [49:0] prod;
   } s1_type;

   typedef struct packed {
      logic [15:0] q0;
      logic [10:0] r0;
      logic [6:0]  lo7;
   } s2_type;

   typedef struct packed {
      logic [15:0] days;
      logic [16:0] sod;
   } s3_type;

   typedef struct packed {
      logic [6:0]  cent;
      logic [17:0] r;
      logic [33:0] p_min;
      logic [16:0] sod;
      logic [32:0] p_wd;
      logic [15:0] d1;
   } s4_type;

   typedef struct packed {
      logic [6:0]  cent;
      logic [17:0] r;
      logic [35:0] p_yy;
      logic [10:0] min0;
      logic [6:0]  se0;
      logic [3:0]  wrem;
   } s5_type;

   typedef struct packed {
      logic [6:0]  cent;
      logic [6:0]  yy0;
      logic [11:0] r2a;
      logic [10:0] mins;
      logic [5:0]  se;
      logic [2:0]  wd;
   } s6_type;

   typedef struct packed {
      logic [6:0]  cent;
      logic [6:0]  yy;
      logic [10:0] r3;
      logic [20:0] p_hr;
      logic [10:0] mins;
      logic [5:0]  se;
      logic [2:0]  wd;
   } s7_type;

   typedef struct packed {
      logic [6:0]  cent;
      logic [6:0]  yy;
      logic [10:0] r3;
      logic [19:0] p_mm;
      logic [4:0]  hr0;
      logic [6:0]  mrem;
      logic [5:0]  se;
      logic [2:0]  wd;
   } s8_type;

   typedef struct packed {
      logic [6:0] cent;
      logic [6:0] yy;
      logic [3:0] mm0;
      logic [8:0] r4a;
      logic [4:0] hr;
      logic [5:0] mi;
      logic [5:0] se;
      logic [2:0] wd;
   } s9_type;

   typedef struct packed {
      logic [6:0]  cent;
      logic [6:0]  yy;
      logic [3:0]  mm;
      logic [14:0] p_d;
      logic [4:0]  hr;
      logic [5:0]  mi;
      logic [5:0]  se;
      logic [2:0]  wd;
   } s10_type;

   typedef struct packed {
      logic [YearW-1:0] year;
      logic [MonW-1:0]  month;
      logic [DomW-1:0]  dom;
      logic [HourW-1:0] hr;
      logic [MinW-1:0]  mi;
      logic [SecW-1:0]  se;
      logic [WdayW-1:0] wd;
      logic             resync;
   } out_type;

   s1_type  s1_ff,  s1_in;
   s2_type  s2_ff,  s2_in;
   s3_type  s3_ff,  s3_in;
   s4_type  s4_ff,  s4_in;
   s5_type  s5_ff,  s5_in;
   s6_type  s6_ff,  s6_in;
   s7_type  s7_ff,  s7_in;
   s8_type  s8_ff,  s8_in;
   s9_type  s9_ff,  s9_in;
   s10_type s10_ff, s10_in;
   out_type out_ff, out_in;

   logic [Stages-1:0] vld_ff, vld_in;
   logic              adv;

   // working values
   logic [10:0] rem3;
   logic [21:0] jd;
   logic [23:0] cen_arg;
   logic [23:0] cen_sub;
   logic [23:0] r1;
   logic [12:0] wd0;
   logic [11:0] r2;
   logic [12:0] yr_sum;

   // whole pipe moves together; it stalls only while the result is held
   assign adv       = !vld_ff[Stages-1] || rsp_ready;
   assign in_ready  = adv;
   assign vld_in    = {vld_ff[Stages-2:0], in_valid};

   always_comb begin
      rem3    = '0;
      jd      = '0;
      cen_arg = '0;
      cen_sub = '0;
      r1      = '0;
      wd0     = '0;
      r2      = '0;
      yr_sum  = '0;

      // split local seconds: low 7 bits pass, rest divided by 675
      s1_in.x    = in_local[NtpW-1:7];
      s1_in.lo7  = in_local[6:0];
      s1_in.prod = 50'(s1_in.x) * 50'(DayRecip);

      s2_in.q0  = s1_ff.prod[49:34];
      s2_in.r0  = 11'(26'(s1_ff.x) - 26'(s2_in.q0) * 26'(DayOdd));
      s2_in.lo7 = s1_ff.lo7;

      // reciprocal estimate is low by at most one
      if (s2_ff.r0 >= 11'(DayOdd)) begin
         s3_in.days = s2_ff.q0 + 1'b1;
         rem3       = s2_ff.r0 - 11'(DayOdd);
      end else begin
         s3_in.days = s2_ff.q0;
         rem3       = s2_ff.r0;
      end
      s3_in.sod = {rem3[9:0], s2_ff.lo7};

      // century from day count; 32-bit range keeps it within 66..68
      jd      = 22'(s3_ff.days) + CjdEpoch;
      cen_arg = {jd, 2'b00} + CentBias;
      if (cen_arg >= Cent68At) begin
         s4_in.cent = 7'd68;
         cen_sub    = Cent68At;
      end else if (cen_arg >= Cent67At) begin
         s4_in.cent = 7'd67;
         cen_sub    = Cent67At;
      end else begin
         s4_in.cent = 7'd66;
         cen_sub    = 24'(66 * 146097);
      end
      r1          = cen_arg - cen_sub;
      s4_in.r     = r1[17:0] | 18'd3;
      s4_in.p_min = 34'(s3_ff.sod) * 34'(MinRecip);
      s4_in.sod   = s3_ff.sod;
      s4_in.d1    = s3_ff.days + 1'b1;
      s4_in.p_wd  = 33'(s4_in.d1) * 33'(WdRecip);

      s5_in.cent = s4_ff.cent;
      s5_in.r    = s4_ff.r;
      s5_in.p_yy = 36'(s4_ff.r) * 36'(YearRecip);
      s5_in.min0 = s4_ff.p_min[32:22];
      s5_in.se0  = 7'(s4_ff.sod - 17'(s5_in.min0) * 17'(Sixty));
      wd0        = s4_ff.p_wd[31:19];
      s5_in.wrem = 4'(s4_ff.d1 - 16'(wd0) * 16'(Seven));

      s6_in.cent = s5_ff.cent;
      s6_in.yy0  = s5_ff.p_yy[34:28];
      s6_in.r2a  = 12'(s5_ff.r - 18'(s6_in.yy0) * 18'(QuadYear));
      if (s5_ff.se0 >= 7'(Sixty)) begin
         s6_in.mins = s5_ff.min0 + 1'b1;
         s6_in.se   = 6'(s5_ff.se0 - 7'(Sixty));
      end else begin
         s6_in.mins = s5_ff.min0;
         s6_in.se   = s5_ff.se0[5:0];
      end
      s6_in.wd = (s5_ff.wrem >= 4'(Seven)) ? 3'(s5_ff.wrem - 4'(Seven))
                                           : s5_ff.wrem[2:0];

      s7_in.cent = s6_ff.cent;
      if (s6_ff.r2a >= 12'(QuadYear)) begin
         s7_in.yy = s6_ff.yy0 + 1'b1;
         r2       = s6_ff.r2a - 12'(QuadYear);
      end else begin
         s7_in.yy = s6_ff.yy0;
         r2       = s6_ff.r2a;
      end
      s7_in.r3   = 11'(11'(r2[11:2]) * 11'd5) + 11'd2;
      s7_in.p_hr = 21'(s6_ff.mins) * 21'(HourRecip);
      s7_in.mins = s6_ff.mins;
      s7_in.se   = s6_ff.se;
      s7_in.wd   = s6_ff.wd;

      s8_in.cent = s7_ff.cent;
      s8_in.yy   = s7_ff.yy;
      s8_in.r3   = s7_ff.r3;
      s8_in.p_mm = 20'(s7_ff.r3) * 20'(MonRecip);
      s8_in.hr0  = s7_ff.p_hr[20:16];
      s8_in.mrem = 7'(s7_ff.mins - 11'(s8_in.hr0) * 11'(Sixty));
      s8_in.se   = s7_ff.se;
      s8_in.wd   = s7_ff.wd;

      s9_in.cent = s8_ff.cent;
      s9_in.yy   = s8_ff.yy;
      s9_in.mm0  = s8_ff.p_mm[19:16];
      s9_in.r4a  = 9'(s8_ff.r3 - 11'(s9_in.mm0) * 11'(MonSpan));
      if (s8_ff.mrem >= 7'(Sixty)) begin
         s9_in.hr = s8_ff.hr0 + 1'b1;
         s9_in.mi = 6'(s8_ff.mrem - 7'(Sixty));
      end else begin
         s9_in.hr = s8_ff.hr0;
         s9_in.mi = s8_ff.mrem[5:0];
      end
      s9_in.se = s8_ff.se;
      s9_in.wd = s8_ff.wd;

      s10_in.cent = s9_ff.cent;
      s10_in.yy   = s9_ff.yy;
      if (s9_ff.r4a >= 9'(MonSpan)) begin
         s10_in.mm  = s9_ff.mm0 + 1'b1;
         s10_in.p_d = 15'(8'(s9_ff.r4a - 9'(MonSpan))) * 15'(DomRecip);
      end else begin
         s10_in.mm  = s9_ff.mm0;
         s10_in.p_d = 15'(s9_ff.r4a[7:0]) * 15'(DomRecip);
      end
      s10_in.hr = s9_ff.hr;
      s10_in.mi = s9_ff.mi;
      s10_in.se = s9_ff.se;
      s10_in.wd = s9_ff.wd;

      // March-based month back to calendar month; Jan and Feb roll the year
      yr_sum     = 13'(s10_ff.cent) * 13'd100 + 13'(s10_ff.yy) - YearBias;
      out_in.dom = 5'(s10_ff.p_d[14:10]) + 1'b1;
      if (s10_ff.mm < 4'd10) begin
         out_in.month = s10_ff.mm + 4'd3;
         out_in.year  = yr_sum[YearW-1:0];
      end else begin
         out_in.month = s10_ff.mm - 4'd9;
         out_in.year  = yr_sum[YearW-1:0] + 1'b1;
      end
      out_in.hr     = s10_ff.hr;
      out_in.mi     = s10_ff.mi;
      out_in.se     = s10_ff.se;
      out_in.wd     = s10_ff.wd;
      out_in.resync = (s10_ff.mi == 6'd29 || s10_ff.mi == 6'd59) && s10_ff.se == 6'd30;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid          = vld_ff[Stages-1];
   assign rsp_year           = out_ff.year;
   assign rsp_month          = out_ff.month;
   assign rsp_day_of_month   = out_ff.dom;
   assign rsp_hour           = out_ff.hr;
   assign rsp_minute         = out_ff.mi;
   assign rsp_second         = out_ff.se;
   assign rsp_weekday        = out_ff.wd;
   assign rsp_resync_request = out_ff.resync;

endmodule

[design/ntp_seconds_to_calendar.sv]
// NTP seconds to local calendar. Each request word is an NTP seconds count
// (epoch 1900-01-01 UTC). A count not strictly greater than the newest one
// taken is dropped without a response; a newer one is shifted by the
// signed timezone offset (modulo 2^32) and returns one response word with
// year, month, day, hour, minute, second, weekday (0 = Sunday) and a resync
// flag set at minute 29 or 59, second 30. A new request is taken every
// cycle while the input queue has room, then passes the 11-stage conversion
// pipe. The offset resets to +9 hours; the user writes it through the csr
// port only while no word is in flight; the block does not enforce this.
module ntp_seconds_to_calendar
   import ntc_pkg::*;
#(
   parameter int QueueDepth = NtcQueueDepth
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [NtpW-1:0]       req_ntp_seconds,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [YearW-1:0]      rsp_year,
   output logic [MonW-1:0]       rsp_month,
   output logic [DomW-1:0]       rsp_day_of_month,
   output logic [HourW-1:0]      rsp_hour,
   output logic [MinW-1:0]       rsp_minute,
   output logic [SecW-1:0]       rsp_second,
   output logic [WdayW-1:0]      rsp_weekday,
   output logic                  rsp_resync_request,
   // timezone offset register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic signed [TzW-1:0] csr_timezone_offset
);

`include "assert_macros.svh"

   ntc_push_type    push;
   ntc_qstat_type   qstat;
   logic            push_ready;
   logic            pop_valid;
   logic            pop_ready;
   logic [NtpW-1:0] pop_data;

   // Front end: drop stale counts, apply the offset, hand newer words on.
   ntc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_ntp_seconds     (req_ntp_seconds),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_timezone_offset (csr_timezone_offset),
      .push_ready          (push_ready),
      .push                (push)
   );

   // Short queue decouples a stalled response from the request side.
   ntc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .stat       (qstat)
   );

   // Back end: day split, Gregorian date, time of day and weekday.
   ntc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (pop_valid),
      .in_ready           (pop_ready),
      .in_local           (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_year           (rsp_year),
      .rsp_month          (rsp_month),
      .rsp_day_of_month   (rsp_day_of_month),
      .rsp_hour           (rsp_hour),
      .rsp_minute         (rsp_minute),
      .rsp_second         (rsp_second),
      .rsp_weekday        (rsp_weekday),
      .rsp_resync_request (rsp_resync_request)
   );

   // a word enters the queue only from an accepted request
   `ASSERT_PROP(a_push_from_accept, clock, reset, push.valid |-> (req_valid && req_ready))
   // a pushed word leaves the queue non-empty on the next cycle
   `ASSERT_PROP(a_push_lands, clock, reset, push.valid |=> !qstat.empty)
   // queue occupancy flags stay consistent
   `ASSERT_NEVER(a_queue_flags, clock, reset, qstat.full && qstat.empty)

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import ntc_pkg::*;

   localparam longint unsigned DaySecs    = 86400;
   localparam longint unsigned JulianBase = 2415021;
   localparam int SettleCycles = 20;                  // allow margin beyond the pipe depth
   localparam longint unsigned SweepEnd   = 64'd4294900000;
   localparam int RandomResults = 800;

   // local-time instants the sweep must land on exactly (end of the day before a rollover)
   localparam longint unsigned Landmark [4] = '{
      64'd3155673599,   // 1999-12-31 23:59:59
      64'd3160771199,   // 2000-02-28 23:59:59
      64'd3160857599,   // 2000-02-29 23:59:59
      64'd4170700799    // 2032-02-29 23:59:59
   };

   typedef enum logic [1:0] {
      DO_COUNT,    // send one NTP count on the request channel
      DO_SETTLE,   // hold the sender until every calendar word is back
      DO_TZ        // write the timezone offset
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [31:0]   value;
   } stim_word_type;

   typedef struct packed {
      logic [YearW-1:0] year;
      logic [MonW-1:0]  month;
      logic [DomW-1:0]  day_of_month;
      logic [HourW-1:0] hour;
      logic [MinW-1:0]  minute;
      logic [SecW-1:0]  second;
      logic [WdayW-1:0] weekday;
      logic             resync_request;
   } cal_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [NtpW-1:0]       req_ntp_seconds = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [YearW-1:0]      rsp_year;
   logic [MonW-1:0]       rsp_month;
   logic [DomW-1:0]       rsp_day_of_month;
   logic [HourW-1:0]      rsp_hour;
   logic [MinW-1:0]       rsp_minute;
   logic [SecW-1:0]       rsp_second;
   logic [WdayW-1:0]      rsp_weekday;
   logic                  rsp_resync_request;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic signed [TzW-1:0] csr_timezone_offset = '0;

   stim_word_type pending_steps[$];   // stimulus program, filled before reset releases
   cal_type       calendar_due[$];    // predicted calendar words, oldest first

   // sender-side model state
   logic [TzW-1:0]  tz_model;
   logic [NtpW-1:0] newest_count;

   // generator bookkeeping
   logic [TzW-1:0]  gen_tz = TzW'(9 * 3600);
   logic [NtpW-1:0] gen_newest = '0;
   int total_counts = 0;
   int total_results = 0;
   int stale_counts = 0;
   int tz_writes = 0;
   int quiet_counts;
   int quiet_results;

   int counts_accepted = 0;
   int results_checked = 0;
   int error_count = 0;
   int gap_left = 0;
   int settle_wait = 0;
   int stall_left = 0;
   bit req_done;
   bit csr_done;
   cal_type got;

   ntp_seconds_to_calendar i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_ntp_seconds     (req_ntp_seconds),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_year            (rsp_year),
      .rsp_month           (rsp_month),
      .rsp_day_of_month    (rsp_day_of_month),
      .rsp_hour            (rsp_hour),
      .rsp_minute          (rsp_minute),
      .rsp_second          (rsp_second),
      .rsp_weekday         (rsp_weekday),
      .rsp_resync_request  (rsp_resync_request),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_timezone_offset (csr_timezone_offset)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sign-extend the 17-bit offset to the 32-bit count width
   function automatic logic [31:0] widen_tz(logic [TzW-1:0] o);
      return {{(32 - TzW){o[TzW-1]}}, o};
   endfunction

   // Convert one count to local calendar fields: shift by the offset modulo 2^32,
   // split into chronological Julian day and seconds of day, then walk the
   // Gregorian 400-year, 4-year and 5-month cycles down to year/month/day.
   function automatic cal_type ntp_to_local_calendar(logic [31:0] count, logic [TzW-1:0] ofs);
      logic [31:0] local_secs;
      longint unsigned jd, sod, cent, r, yy, mm, dd, mi, se;
      cal_type res;
      local_secs = count + widen_tz(ofs);
      jd   = 64'(local_secs) / DaySecs + JulianBase;
      sod  = 64'(local_secs) % DaySecs;
      cent = (jd * 4 + 128179) / 146097;
      r    = (jd * 4 + 128179 - cent * 146097) / 4 * 4 + 3;
      yy   = r / 1461;
      r    = (r - yy * 1461) / 4 * 5 + 2;
      mm   = r / 153;
      dd   = (r - mm * 153) / 5 + 1;
      yy   = cent * 100 + yy - 4800;
      // the cycle starts in March; fold Jan and Feb into the next year
      if (mm < 10) begin
         mm = mm + 3;
      end else begin
         mm = mm - 9;
         yy = yy + 1;
      end
      mi = (sod / 60) % 60;
      se = sod % 60;
      res.year           = YearW'(yy);
      res.month          = MonW'(mm);
      res.day_of_month   = DomW'(dd);
      res.hour           = HourW'(sod / 3600);
      res.minute         = MinW'(mi);
      res.second         = SecW'(se);
      res.weekday        = WdayW'((jd + 1) % 7);
      res.resync_request = (mi % 30 == 29) && (se == 30);
      return res;
   endfunction

   function automatic string cal_text(cal_type c);
      return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd=%0d resync=%0d", c.year, c.month,
                       c.day_of_month, c.hour, c.minute, c.second, c.weekday,
                       c.resync_request);
   endfunction

   task automatic push_count(longint unsigned c);
      pending_steps.push_back('{DO_COUNT, 32'(c)});
      total_counts++;
      if (32'(c) > gen_newest) begin
         gen_newest = 32'(c);
         total_results++;
      end else begin
         stale_counts++;
      end
   endtask

   // drain first so the write lands while the block is idle
   task automatic push_tz(int ofs);
      pending_steps.push_back('{DO_SETTLE, 32'd0});
      pending_steps.push_back('{DO_TZ, 32'(ofs)});
      gen_tz = TzW'(ofs);
      tz_writes++;
   endtask

   // Driver: retire the word accepted at this edge, predict its calendar word,
   // then pick what to present next from the stimulus program.
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         csr_valid    <= 1'b0;
         gap_left     = 0;
         settle_wait  = 0;
         tz_model     = TzW'(9 * 3600);
         newest_count = '0;
      end else begin
         req_done = req_valid && req_ready;
         csr_done = csr_valid && csr_ready;
         if (req_done) begin
            counts_accepted++;
            // stale counts are dropped and leave the newest count alone
            if (req_ntp_seconds > newest_count) begin
               newest_count = req_ntp_seconds;
               calendar_due.push_back(ntp_to_local_calendar(req_ntp_seconds, tz_model));
            end
            void'(pending_steps.pop_front());
         end
         if (csr_done) begin
            tz_model = csr_timezone_offset;
            void'(pending_steps.pop_front());
         end

         if ((req_valid && !req_done) || (csr_valid && !csr_done)) begin
            // hold the word until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
         end else if (pending_steps.size() == 0) begin
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
         end else begin
            case (pending_steps[0].kind)
               DO_COUNT: begin
                  csr_valid <= 1'b0;
                  if (counts_accepted < quiet_counts && $urandom_range(0, 7) == 0) begin
                     gap_left = $urandom_range(1, 7) - 1;
                     req_valid <= 1'b0;
                  end else begin
                     req_valid       <= 1'b1;
                     req_ntp_seconds <= pending_steps[0].value;
                  end
               end
               DO_TZ: begin
                  req_valid           <= 1'b0;
                  csr_valid           <= 1'b1;
                  csr_timezone_offset <= pending_steps[0].value[TzW-1:0];
               end
               default: begin
                  // DO_SETTLE: wait for the last word, then let the pipe run dry
                  req_valid <= 1'b0;
                  csr_valid <= 1'b0;
                  if (calendar_due.size() == 0) begin
                     if (settle_wait >= SettleCycles) begin
                        settle_wait = 0;
                        void'(pending_steps.pop_front());
                     end else begin
                        settle_wait++;
                     end
                  end
               end
            endcase
         end
      end
   end

   // Monitor: check each accepted calendar word against the oldest prediction,
   // and stall the response channel in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_year, rsp_month, rsp_day_of_month, rsp_hour, rsp_minute,
                    rsp_second, rsp_weekday, rsp_resync_request};
            if (calendar_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: calendar word with none pending: %s", $realtime,
                           cal_text(got));
            end else begin
               if (got !== calendar_due[0]) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: calendar word %0d mismatch: expected %s, got %s",
                              $realtime, results_checked, cal_text(calendar_due[0]),
                              cal_text(got));
               end
               void'(calendar_due.pop_front());
            end
            results_checked++;
         end

         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (results_checked < quiet_results && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Build the stimulus program, release reset, wait for the last word.
   initial begin
      longint unsigned c, lc, avg;
      logic [31:0] lsec;
      int i, k, pick;
      bit lm_done [4];

      // right after reset: offset is +9 h, a zero count is stale, repeats are stale
      push_count(0);
      push_count(1);
      push_count(1);
      push_count(5);
      // most negative legal offset: small counts wrap to early 2036
      push_tz(-50400);
      push_count(6);
      push_count(50399);
      push_count(50400);
      push_count(50401);
      // most negative 17-bit pattern, beyond the legal range
      push_tz(-65536);
      push_count(65535);
      push_count(65536);
      // UTC: 1900 is not a leap year, resync at minutes 29 and 59, year rollover
      push_tz(0);
      push_count(5097599);
      push_count(5097600);
      push_count(5099370);
      push_count(5101170);
      push_count(5101171);
      push_count(31535999);
      push_count(31536000);
      // largest positive 17-bit pattern
      push_tz(65535);

      // Random sweep: counts climb through the whole 32-bit span so every
      // count is new, with a few stale counts mixed in and snaps onto
      // day ends and resync instants.
      for (i = 0; i < RandomResults; i++) begin
         if (i > 0 && i % 180 == 0) begin
            case ((i / 180) % 4)
               0:       push_tz(-50400);
               1:       push_tz(50400);
               2:       push_tz(0);
               default: push_tz(int'($urandom_range(0, 100800)) - 50400);
            endcase
         end
         avg = (SweepEnd - 64'(gen_newest)) / 64'(RandomResults - i);
         if (avg < 1)
            avg = 1;
         pick = $urandom_range(0, 19);
         if (pick < 4)
            c = 64'(gen_newest) + $urandom_range(1, 120);
         else
            c = 64'(gen_newest) + 1 + (64'($urandom) % (2 * avg));
         lsec = 32'(c) + widen_tz(gen_tz);
         if (pick == 16 || pick == 19)
            c = c + (DaySecs - 1 - 64'(lsec) % DaySecs);
         else if (pick == 17 || pick == 18)
            c = c + (64'd3570 - 64'(lsec) % 1800) % 1800;
         if (c > SweepEnd)
            c = 64'(gen_newest) + 1;
         for (k = 0; k < 4; k++) begin
            lc = 64'(32'(Landmark[k]) - widen_tz(gen_tz));
            if (!lm_done[k] && lc > 64'(gen_newest) && lc <= c) begin
               push_count(lc);
               push_count(lc + 1);
               lm_done[k] = 1'b1;
            end
         end
         if (c <= 64'(gen_newest))
            c = 64'(gen_newest) + 1;
         push_count(c);
         if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1) == 0)
               push_count(gen_newest);
            else
               push_count($urandom_range(0, gen_newest));
         end
      end

      // largest legal offset at the top of the span: local time wraps to 1900
      push_tz(50400);
      push_count(64'd4294916895);
      push_count(64'd4294916896);
      push_count(64'hFFFF_FFFE);
      push_count(64'hFFFF_FFFF);
      push_count(64'hFFFF_FFFF);
      push_count(0);

      quiet_counts  = total_counts - 120;
      quiet_results = total_results - 110;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_steps.size() != 0 || calendar_due.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("Sent %0d NTP counts (%0d stale, dropped) under %0d offset settings;",
               counts_accepted, stale_counts, tz_writes + 1);
      $display("checked %0d calendar words, %0d errors.", results_checked, error_count);
      if (error_count == 0) begin
         $display("ntp_seconds_to_calendar verification clean");
      end else begin
         $display("ntp_seconds_to_calendar verification failed");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("Timeout with %0d calendar words outstanding", calendar_due.size());
      $display("ntp_seconds_to_calendar verification failed");
      $finish;
   end

endmodule
